// ----- src/hre_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hre_pkg: shared types and constants of the HTTP request header extractor
// Result item layout, per-byte result bundle, kind codes and name tables.
// ----------------------------------------------------------------------------
package hre_pkg;

	localparam int MaxRes = 3;

	localparam logic [2:0] K_VALUE  = 3'd0;
	localparam logic [2:0] K_END    = 3'd1;
	localparam logic [2:0] K_METHOD = 3'd2;
	localparam logic [2:0] K_NUMBER = 3'd3;
	localparam logic [2:0] K_DONE   = 3'd4;
	localparam logic [2:0] K_BAD    = 3'd5;

	localparam logic [3:0] F_PATH  = 4'd0;
	localparam logic [3:0] F_QUERY = 4'd1;

	// header name slots; field_id is slot + 2
	localparam int         NumNames = 11;
	localparam logic [4:0] SLOT_KA  = 5'd9;
	localparam logic [4:0] SLOT_CL  = 5'd10;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef struct packed {
		logic [2:0]         out_kind;
		logic [3:0]         field_id;
		logic [7:0]         value_byte;
		logic [1:0]         method_code;
		logic signed [31:0] number_value;
		logic               last_of_step;
	} result_t;

	typedef struct packed {
		logic [1:0]              cnt;
		result_t [MaxRes-1:0]    r;
	} bundle_t;

	function automatic logic [4:0] hdr_len(input logic [3:0] i);
		logic [4:0] l;
		unique case (i)
			4'd0:    l = 5'd6;
			4'd1:    l = 5'd12;
			4'd2:    l = 5'd8;
			4'd3:    l = 5'd17;
			4'd4:    l = 5'd17;
			4'd5:    l = 5'd16;
			4'd6:    l = 5'd8;
			4'd7:    l = 5'd9;
			4'd8:    l = 5'd14;
			4'd9:    l = 5'd12;
			4'd10:   l = 5'd15;
			default: l = 5'd0;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] hdr_chr(input logic [3:0] i, input logic [4:0] pos);
		logic [135:0] nm;
		logic [135:0] sh;
		unique case (i)
			4'd0:    nm = {"HOST: ", {11{8'h00}}};
			4'd1:    nm = {"USER-AGENT: ", {5{8'h00}}};
			4'd2:    nm = {"ACCEPT: ", {9{8'h00}}};
			4'd3:    nm = "ACCEPT-LANGUAGE: ";
			4'd4:    nm = "ACCEPT-ENCODING: ";
			4'd5:    nm = {"ACCEPT-CHARSET: ", 8'h00};
			4'd6:    nm = {"COOKIE: ", {9{8'h00}}};
			4'd7:    nm = {"REFERER: ", {8{8'h00}}};
			4'd8:    nm = {"CONTENT-TYPE: ", {3{8'h00}}};
			4'd9:    nm = {"KEEP-ALIVE: ", {5{8'h00}}};
			4'd10:   nm = {"CONTENT-LENGTH:", {2{8'h00}}};
			default: nm = '0;
		endcase
		sh = nm << {pos, 3'b000};
		return sh[135:128];
	endfunction

	function automatic logic [2:0] meth_len(input logic [1:0] i);
		return (i == 2'd0) ? 3'd3 : 3'd4;
	endfunction

	function automatic logic [7:0] meth_chr(input logic [1:0] i, input logic [4:0] pos);
		logic [31:0] nm;
		logic [31:0] sh;
		unique case (i)
			2'd0:    nm = {"GET", 8'h00};
			2'd1:    nm = "POST";
			2'd2:    nm = "HEAD";
			default: nm = '0;
		endcase
		sh = nm << {pos, 3'b000};
		return sh[31:24];
	endfunction

endpackage
`default_nettype wire

// ----- src/hre_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hre_in_if: request byte channel
// Valid/ready channel carrying one request byte and its end-of-buffer mark.
// ----------------------------------------------------------------------------
interface hre_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source(output valid, output data_byte, output end_of_buffer, input ready);
	modport sink(input valid, input data_byte, input end_of_buffer, output ready);
endinterface
`default_nettype wire

// ----- src/hre_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hre_out_if: result channel
// Valid/ready channel carrying one extracted result item.
// ----------------------------------------------------------------------------
interface hre_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         out_kind;
	logic [3:0]         field_id;
	logic [7:0]         value_byte;
	logic [1:0]         method_code;
	logic signed [31:0] number_value;
	logic               last_of_step;

	modport source(output valid, output out_kind, output field_id, output value_byte,
		output method_code, output number_value, output last_of_step, input ready);
	modport sink(input valid, input out_kind, input field_id, input value_byte,
		input method_code, input number_value, input last_of_step, output ready);
endinterface
`default_nettype wire

// ----- src/http_request_header_extractor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_header_extractor: streaming HTTP request header extractor
// Parses method, URI path/query and selected header values from a byte stream.
// ----------------------------------------------------------------------------
// Throughput: one request byte per cycle while the bundle queue is not full and
//   each byte yields at most one result; a byte yielding k results holds the
//   result port for k handshakes; results are registered in the bundle queue.
// The parser takes all of a byte's work in the accepting cycle; the two-entry
//   bundle queue lets it keep accepting while results wait to be taken.
// Reset: arst_n clears parse state, queue pointers and serializer index at once.
module http_request_header_extractor (
	input  wire logic clk,
	input  wire logic arst_n,
	hre_in_if.sink    req_in,
	hre_out_if.source res_out
);
	import hre_pkg::*;

	bundle_t push_bundle;
	bundle_t head;
	logic    push;
	logic    pop;
	logic    full;
	logic    empty;

	// front: classify each byte and form its result bundle
	hre_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_in),
		.full   (full),
		.push   (push),
		.bundle (push_bundle)
	);

	// hold bundles between parser and serializer
	hre_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_bundle),
		.pop    (pop),
		.full   (full),
		.empty  (empty),
		.head   (head)
	);

	// back: advance through each bundle one result at a time
	hre_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.res    (res_out)
	);

endmodule
`default_nettype wire

// ----- src/hre_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hre_front: byte parser
// Accepts one request byte, advances the parse state and forms its results.
// ----------------------------------------------------------------------------
module hre_front (
	input  wire logic      clk,
	input  wire logic      arst_n,
	hre_in_if.sink         req,
	input  wire logic      full,
	output logic           push,
	output hre_pkg::bundle_t bundle
);
	import hre_pkg::*;

	typedef enum logic [3:0] {
		P_METHOD, P_METHOD_TAIL, P_URI_GAP, P_PATH, P_QUERY, P_LINE_TAIL,
		P_HDR_NAME, P_HDR_NAME_TAIL, P_HDR_GAP, P_HDR_VALUE, P_NUM_SIGN,
		P_NUM_DIGITS, P_NUM_STOP, P_HDR_IGNORE, P_DONE, P_DEAD
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  method_seen;
		logic [4:0]  pos;
		logic [10:0] cand;
		logic [10:0] taken;
		logic [31:0] acc;
		logic        neg;
		logic        pending_cr;
	} pstate_t;

	typedef struct packed {
		pstate_t s;
		logic    v;
		result_t r;
	} dret_t;

	localparam pstate_t RST = '{phase: P_METHOD, method_seen: 2'd0, pos: 5'd0,
		cand: 11'h7FF, taken: 11'd0, acc: 32'd0, neg: 1'b0, pending_cr: 1'b0};

	function automatic result_t mk(input logic [2:0] k, input logic [3:0] f,
		input logic [7:0] b, input logic [1:0] m, input logic [31:0] n);
		result_t r;
		r.out_kind     = k;
		r.field_id     = f;
		r.value_byte   = b;
		r.method_code  = m;
		r.number_value = n;
		r.last_of_step = 1'b0;
		return r;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0B || b == 8'h0C
			|| b == 8'h0D;
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
	endfunction

	function automatic logic is_num(input logic [4:0] p);
		return p == SLOT_KA || p == SLOT_CL;
	endfunction

	function automatic logic [31:0] num_result(input pstate_t s);
		if (s.neg)
			return 32'd0 - s.acc;
		return s.acc[31] ? 32'h7FFF_FFFF : s.acc;
	endfunction

	function automatic pstate_t num_feed(input pstate_t si, input logic [7:0] b);
		pstate_t    s;
		logic [35:0] t;
		s = si;
		t = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {32'd0, b[3:0]};
		if (s.phase == P_NUM_SIGN && (b == 8'h2D || b == 8'h2B)) begin
			s.neg   = (b == 8'h2D);
			s.phase = P_NUM_DIGITS;
		end else if ((s.phase == P_NUM_SIGN || s.phase == P_NUM_DIGITS)
			&& b >= 8'h30 && b <= 8'h39) begin
			s.acc   = (t > 36'h0_8000_0000) ? 32'h8000_0000 : t[31:0];
			s.phase = P_NUM_DIGITS;
		end else begin
			s.phase = P_NUM_STOP;
		end
		return s;
	endfunction

	function automatic pstate_t start_line(input pstate_t si);
		pstate_t s;
		s       = si;
		s.phase = P_HDR_NAME;
		s.pos   = 5'd0;
		s.cand  = ~s.taken;
		return s;
	endfunction

	function automatic dret_t data_step(input pstate_t si, input logic [7:0] b);
		dret_t       d;
		logic [10:0] keep;
		logic        hit;
		logic [3:0]  fid;
		logic [7:0]  ub;
		d.s  = si;
		d.v  = 1'b0;
		d.r  = mk(K_VALUE, F_PATH, 8'd0, 2'd0, 32'd0);
		keep = '0;
		hit  = 1'b0;
		ub   = upcase(b);
		fid  = 4'(si.pos + 5'd2);
		unique case (si.phase)
			P_METHOD: begin
				for (int i = 0; i < 3; i++)
					if (si.cand[i] && si.pos < {2'b00, meth_len(2'(i))}
						&& ub == meth_chr(2'(i), si.pos))
						keep[i] = 1'b1;
				d.s.cand = keep;
				if (keep == '0) begin
					d.v       = 1'b1;
					d.r       = mk(K_BAD, F_PATH, 8'd0, 2'd0, 32'd0);
					d.s.phase = P_DEAD;
				end else begin
					for (int i = 0; i < 3; i++)
						if (!hit && keep[i] && si.pos + 5'd1 == {2'b00, meth_len(2'(i))}) begin
							hit             = 1'b1;
							d.s.method_seen = 2'(i + 1);
							d.v             = 1'b1;
							d.r             = mk(K_METHOD, F_PATH, 8'd0, 2'(i + 1), 32'd0);
							d.s.phase       = P_METHOD_TAIL;
						end
					if (!hit)
						d.s.pos = si.pos + 5'd1;
				end
			end
			P_METHOD_TAIL: begin
				if (is_blank(b))
					d.s.phase = P_URI_GAP;
			end
			P_URI_GAP: begin
				if (!is_blank(b)) begin
					d.v = 1'b1;
					if (b == 8'h3F) begin
						d.r       = mk(K_END, F_PATH, 8'd0, 2'd0, 32'd0);
						d.s.phase = P_QUERY;
					end else begin
						d.r       = mk(K_VALUE, F_PATH, b, 2'd0, 32'd0);
						d.s.phase = P_PATH;
					end
				end
			end
			P_PATH: begin
				d.v = 1'b1;
				if (is_blank(b)) begin
					d.r       = mk(K_END, F_PATH, 8'd0, 2'd0, 32'd0);
					d.s.phase = P_LINE_TAIL;
				end else if (b == 8'h3F) begin
					d.r       = mk(K_END, F_PATH, 8'd0, 2'd0, 32'd0);
					d.s.phase = P_QUERY;
				end else begin
					d.r = mk(K_VALUE, F_PATH, b, 2'd0, 32'd0);
				end
			end
			P_QUERY: begin
				d.v = 1'b1;
				if (is_blank(b)) begin
					d.r       = mk(K_END, F_QUERY, 8'd0, 2'd0, 32'd0);
					d.s.phase = P_LINE_TAIL;
				end else begin
					d.r = mk(K_VALUE, F_QUERY, b, 2'd0, 32'd0);
				end
			end
			P_HDR_NAME: begin
				for (int i = 0; i < NumNames; i++)
					if (si.cand[i] && si.pos < hdr_len(4'(i)) && ub == hdr_chr(4'(i), si.pos))
						keep[i] = 1'b1;
				d.s.cand = keep;
				if (keep == '0) begin
					d.s.phase = P_HDR_IGNORE;
				end else begin
					for (int i = 0; i < NumNames; i++)
						if (!hit && keep[i] && si.pos + 5'd1 == hdr_len(4'(i))) begin
							hit = 1'b1;
							if (5'(i) != SLOT_CL)
								d.s.taken[i] = 1'b1;
							d.s.pos   = 5'(i);
							d.s.acc   = 32'd0;
							d.s.neg   = 1'b0;
							d.s.phase = (5'(i) == SLOT_CL) ? P_HDR_NAME_TAIL : P_HDR_GAP;
						end
					if (!hit)
						d.s.pos = si.pos + 5'd1;
				end
			end
			P_HDR_NAME_TAIL: begin
				if (is_blank(b))
					d.s.phase = P_HDR_GAP;
			end
			P_HDR_GAP: begin
				if (!is_blank(b)) begin
					if (is_num(si.pos)) begin
						d.s.phase = P_NUM_SIGN;
						d.s       = num_feed(d.s, b);
					end else begin
						d.v       = 1'b1;
						d.r       = mk(K_VALUE, fid, b, 2'd0, 32'd0);
						d.s.phase = P_HDR_VALUE;
					end
				end
			end
			P_HDR_VALUE: begin
				d.v = 1'b1;
				d.r = mk(K_VALUE, fid, b, 2'd0, 32'd0);
			end
			P_NUM_SIGN, P_NUM_DIGITS: begin
				d.s = num_feed(si, b);
			end
			default: begin
			end
		endcase
		return d;
	endfunction

	function automatic dret_t line_end(input pstate_t si);
		dret_t      d;
		logic [3:0] fid;
		d.s = si;
		d.v = 1'b0;
		d.r = mk(K_VALUE, F_PATH, 8'd0, 2'd0, 32'd0);
		fid = 4'(si.pos + 5'd2);
		unique case (si.phase)
			P_METHOD: begin
				d.v       = 1'b1;
				d.r       = mk(K_BAD, F_PATH, 8'd0, 2'd0, 32'd0);
				d.s.phase = P_DEAD;
			end
			P_PATH: begin
				d.v = 1'b1;
				d.r = mk(K_END, F_PATH, 8'd0, 2'd0, 32'd0);
				d.s = start_line(si);
			end
			P_QUERY: begin
				d.v = 1'b1;
				d.r = mk(K_END, F_QUERY, 8'd0, 2'd0, 32'd0);
				d.s = start_line(si);
			end
			P_METHOD_TAIL, P_URI_GAP, P_LINE_TAIL, P_HDR_IGNORE: begin
				d.s = start_line(si);
			end
			P_HDR_NAME: begin
				if (si.pos == 5'd0) begin
					d.v       = 1'b1;
					d.r       = mk(K_DONE, F_PATH, 8'd0, 2'd0, 32'd0);
					d.s.phase = P_DONE;
				end else begin
					d.s = start_line(si);
				end
			end
			P_HDR_NAME_TAIL, P_HDR_GAP, P_HDR_VALUE, P_NUM_SIGN, P_NUM_DIGITS,
			P_NUM_STOP: begin
				d.v = 1'b1;
				if (is_num(si.pos))
					d.r = mk(K_NUMBER, fid, 8'd0, 2'd0, num_result(si));
				else
					d.r = mk(K_END, fid, 8'd0, 2'd0, 32'd0);
				d.s = start_line(si);
			end
			default: begin
			end
		endcase
		return d;
	endfunction

	pstate_t st_q;
	pstate_t st_next;
	bundle_t bnd;
	logic    accept;

	always_comb begin
		dret_t      d1;
		dret_t      d2;
		pstate_t    s;
		logic [1:0] cnt;
		logic [7:0] b;
		logic       eob;
		b   = req.data_byte;
		eob = req.end_of_buffer;
		s   = st_q;
		cnt = 2'd0;
		bnd = '0;
		d1  = '0;
		d2  = '0;
		// first stage: line end, deferred CR, or the byte itself
		if (st_q.pending_cr && b == CH_LF)
			d1 = line_end(st_q);
		else if (st_q.pending_cr)
			d1 = data_step(st_q, CH_CR);
		else if (b != CH_CR)
			d1 = data_step(st_q, b);
		if (st_q.pending_cr || b != CH_CR) begin
			s = d1.s;
			if (d1.v) begin
				bnd.r[cnt] = d1.r;
				cnt        = cnt + 2'd1;
			end
		end
		// second stage: byte after a deferred CR, or a CR flushed at end of buffer
		if ((st_q.pending_cr && b != CH_LF && b != CH_CR) || (eob && b == CH_CR)) begin
			d2 = data_step(s, b);
			s  = d2.s;
			if (d2.v) begin
				bnd.r[cnt] = d2.r;
				cnt        = cnt + 2'd1;
			end
		end
		s.pending_cr = (b == CH_CR) && !eob;
		if (eob) begin
			if (s.phase != P_DONE && s.phase != P_DEAD) begin
				bnd.r[cnt] = mk(K_BAD, F_PATH, 8'd0, 2'd0, 32'd0);
				cnt        = cnt + 2'd1;
			end
			s = RST;
		end
		if (cnt != 2'd0)
			bnd.r[cnt - 2'd1].last_of_step = 1'b1;
		bnd.cnt = cnt;
		st_next = s;
	end

	assign req.ready = !full;
	assign accept    = req.valid && !full;
	assign push      = accept && (bnd.cnt != 2'd0);
	assign bundle    = bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= RST;
		end else if (accept) begin
			st_q <= st_next;
		end
	end

endmodule
`default_nettype wire

// ----- src/hre_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hre_queue: two-entry bundle queue
// Decouples the parser from the result serializer.
// ----------------------------------------------------------------------------
module hre_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire hre_pkg::bundle_t wdata,
	input  wire logic             pop,
	output logic                  full,
	output logic                  empty,
	output hre_pkg::bundle_t      head
);
	import hre_pkg::*;

	bundle_t    mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n) count_q <= 2'd2)
		else $error("queue count overflow");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && count_q == 2'd1) |=> full)
		else $error("queue failed to fill");

endmodule
`default_nettype wire

// ----- src/hre_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hre_back: result serializer
// Drains each queued bundle onto the result channel one item per handshake.
// ----------------------------------------------------------------------------
module hre_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hre_pkg::bundle_t head,
	input  wire logic             empty,
	output logic                  pop,
	hre_out_if.source             res
);
	import hre_pkg::*;

	logic [1:0] idx_q;
	result_t    cur;
	logic       take;
	logic       last;

	assign cur  = head.r[idx_q];
	assign take = !empty && res.ready;
	assign last = (idx_q == head.cnt - 2'd1);
	assign pop  = take && last;

	assign res.valid        = !empty;
	assign res.out_kind     = cur.out_kind;
	assign res.field_id     = cur.field_id;
	assign res.value_byte   = cur.value_byte;
	assign res.method_code  = cur.method_code;
	assign res.number_value = cur.number_value;
	assign res.last_of_step = cur.last_of_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (take) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule
`default_nettype wire

// ----- verif/http_request_header_extractor_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_header_extractor_tb: self-checking bench of the header extractor
// Feeds request bytes on the input channel and compares each result item with
// the results worked out by a behavioral parser kept in step with the block.
// Directed requests come first, then randomized requests, with gaps and stalls.
// ----------------------------------------------------------------------------
module http_request_header_extractor_tb;
	import hre_pkg::*;

	// parser phases of the behavioral parser
	typedef enum logic [3:0] {
		PH_METHOD, PH_METHOD_TAIL, PH_URI_GAP, PH_PATH, PH_QUERY, PH_LINE_TAIL,
		PH_HDR_NAME, PH_HDR_NAME_TAIL, PH_HDR_GAP, PH_HDR_VALUE, PH_NUM_SIGN,
		PH_NUM_DIGITS, PH_NUM_STOP, PH_HDR_IGNORE, PH_DONE, PH_DEAD
	} parse_phase_t;

	localparam logic [31:0] SAT_MAG = 32'h8000_0000;

	logic clk;
	logic arst_n;

	hre_in_if  req_in ();
	hre_out_if res_out ();

	http_request_header_extractor DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_in(req_in.sink),
		.res_out(res_out.source)
	);

	// behavioral parser state
	parse_phase_t pp_phase;
	logic [1:0]   pp_method;
	logic [4:0]   pp_pos;
	logic [10:0]  pp_cand;
	logic [10:0]  pp_taken;
	logic [31:0]  pp_acc;
	logic         pp_neg;
	logic         pp_cr;

	result_t step_res[$];        // results of the byte being predicted
	result_t expected_res[$];    // results still owed by the block

	int mismatches;
	bit timed_out;
	bit stim_done;
	bit hold_results;            // long receiver hold-off request
	int stall_cycles;

	// byte streams: stimulus bytes and end-of-buffer marks
	logic [7:0] req_bytes[$];
	logic       req_eob[$];

	// directed table: one row per byte, typed expectation where obvious
	typedef struct {
		logic [7:0] b;
		logic       eob;
		bit         typed;
		result_t    want;
	} dir_row_t;
	dir_row_t dir_rows[$];

	always #5 clk = ~clk;

	function automatic string hdr_text(input int slot);
		case (slot)
			0: return "HOST: ";
			1: return "USER-AGENT: ";
			2: return "ACCEPT: ";
			3: return "ACCEPT-LANGUAGE: ";
			4: return "ACCEPT-ENCODING: ";
			5: return "ACCEPT-CHARSET: ";
			6: return "COOKIE: ";
			7: return "REFERER: ";
			8: return "CONTENT-TYPE: ";
			9: return "KEEP-ALIVE: ";
			default: return "CONTENT-LENGTH:";
		endcase
	endfunction

	function automatic string meth_text(input int m);
		case (m)
			0: return "GET";
			1: return "POST";
			default: return "HEAD";
		endcase
	endfunction

	function automatic bit is_blank(input logic [7:0] b);
		return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0B || b == 8'h0C ||
			b == 8'h0D;
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] b);
		return (b >= "a" && b <= "z") ? b - 8'd32 : b;
	endfunction

	task automatic add_res(input logic [2:0] k, input logic [3:0] f, input logic [7:0] v,
			input logic [1:0] m, input logic [31:0] n);
		result_t r;
		r.out_kind = k;
		r.field_id = f;
		r.value_byte = v;
		r.method_code = m;
		r.number_value = n;
		r.last_of_step = 1'b0;
		if (step_res.size() < MaxRes)
			step_res.push_back(r);
	endtask

	task automatic parser_reset();
		pp_phase = PH_METHOD;
		pp_method = 2'd0;
		pp_pos = '0;
		pp_cand = '1;
		pp_taken = '0;
		pp_acc = '0;
		pp_neg = 1'b0;
		pp_cr = 1'b0;
	endtask

	task automatic start_line();
		pp_phase = PH_HDR_NAME;
		pp_pos = '0;
		pp_cand = ~pp_taken;
	endtask

	function automatic bit num_slot();
		return pp_pos == SLOT_KA || pp_pos == SLOT_CL;
	endfunction

	function automatic logic [31:0] num_value();
		if (pp_neg)
			return 32'd0 - pp_acc;
		return (pp_acc > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : pp_acc;
	endfunction

	task automatic feed_number(input logic [7:0] b);
		logic [63:0] t;
		if (pp_phase == PH_NUM_SIGN && (b == "-" || b == "+")) begin
			pp_neg = (b == "-");
			pp_phase = PH_NUM_DIGITS;
		end else if ((pp_phase == PH_NUM_SIGN || pp_phase == PH_NUM_DIGITS) &&
				b >= "0" && b <= "9") begin
			t = {32'd0, pp_acc} * 10 + (b - "0");
			pp_acc = (t > SAT_MAG) ? SAT_MAG : t[31:0];
			pp_phase = PH_NUM_DIGITS;
		end else begin
			pp_phase = PH_NUM_STOP;
		end
	endtask

	// advance the parser by one data byte
	task automatic parse_data(input logic [7:0] b);
		logic [10:0] keep;
		string s;
		keep = '0;
		case (pp_phase)
			PH_METHOD: begin
				for (int i = 0; i < 3; i++) begin
					s = meth_text(i);
					if (pp_cand[i] && pp_pos < s.len() && to_upper(b) == s[pp_pos])
						keep[i] = 1'b1;
				end
				pp_cand = keep;
				if (keep == 0) begin
					add_res(K_BAD, 0, 0, 0, 0);
					pp_phase = PH_DEAD;
					return;
				end
				for (int i = 0; i < 3; i++) begin
					s = meth_text(i);
					if (keep[i] && pp_pos + 1 == s.len()) begin
						pp_method = 2'(i + 1);
						add_res(K_METHOD, 0, 0, pp_method, 0);
						pp_phase = PH_METHOD_TAIL;
						return;
					end
				end
				pp_pos++;
			end
			PH_METHOD_TAIL: if (is_blank(b)) pp_phase = PH_URI_GAP;
			PH_URI_GAP: begin
				if (!is_blank(b)) begin
					if (b == "?") begin
						add_res(K_END, F_PATH, 0, 0, 0);
						pp_phase = PH_QUERY;
					end else begin
						add_res(K_VALUE, F_PATH, b, 0, 0);
						pp_phase = PH_PATH;
					end
				end
			end
			PH_PATH: begin
				if (is_blank(b)) begin
					add_res(K_END, F_PATH, 0, 0, 0);
					pp_phase = PH_LINE_TAIL;
				end else if (b == "?") begin
					add_res(K_END, F_PATH, 0, 0, 0);
					pp_phase = PH_QUERY;
				end else begin
					add_res(K_VALUE, F_PATH, b, 0, 0);
				end
			end
			PH_QUERY: begin
				if (is_blank(b)) begin
					add_res(K_END, F_QUERY, 0, 0, 0);
					pp_phase = PH_LINE_TAIL;
				end else begin
					add_res(K_VALUE, F_QUERY, b, 0, 0);
				end
			end
			PH_HDR_NAME: begin
				for (int i = 0; i < NumNames; i++) begin
					s = hdr_text(i);
					if (pp_cand[i] && pp_pos < s.len() && to_upper(b) == s[pp_pos])
						keep[i] = 1'b1;
				end
				pp_cand = keep;
				if (keep == 0) begin
					pp_phase = PH_HDR_IGNORE;
					return;
				end
				for (int i = 0; i < NumNames; i++) begin
					s = hdr_text(i);
					if (keep[i] && pp_pos + 1 == s.len()) begin
						if (i != SLOT_CL)
							pp_taken[i] = 1'b1;
						pp_pos = 5'(i);
						pp_acc = '0;
						pp_neg = 1'b0;
						pp_phase = (i == SLOT_CL) ? PH_HDR_NAME_TAIL : PH_HDR_GAP;
						return;
					end
				end
				pp_pos++;
			end
			PH_HDR_NAME_TAIL: if (is_blank(b)) pp_phase = PH_HDR_GAP;
			PH_HDR_GAP: begin
				if (!is_blank(b)) begin
					if (num_slot()) begin
						pp_phase = PH_NUM_SIGN;
						feed_number(b);
					end else begin
						add_res(K_VALUE, 4'(pp_pos + 5'd2), b, 0, 0);
						pp_phase = PH_HDR_VALUE;
					end
				end
			end
			PH_HDR_VALUE: add_res(K_VALUE, 4'(pp_pos + 5'd2), b, 0, 0);
			PH_NUM_SIGN, PH_NUM_DIGITS: feed_number(b);
			default: ;
		endcase
	endtask

	// close the current line at CR LF
	task automatic parse_line_end();
		case (pp_phase)
			PH_METHOD: begin
				add_res(K_BAD, 0, 0, 0, 0);
				pp_phase = PH_DEAD;
			end
			PH_PATH: begin
				add_res(K_END, F_PATH, 0, 0, 0);
				start_line();
			end
			PH_QUERY: begin
				add_res(K_END, F_QUERY, 0, 0, 0);
				start_line();
			end
			PH_METHOD_TAIL, PH_URI_GAP, PH_LINE_TAIL, PH_HDR_IGNORE: start_line();
			PH_HDR_NAME: begin
				if (pp_pos == 0) begin
					add_res(K_DONE, 0, 0, 0, 0);
					pp_phase = PH_DONE;
				end else begin
					start_line();
				end
			end
			PH_HDR_NAME_TAIL, PH_HDR_GAP, PH_HDR_VALUE, PH_NUM_SIGN, PH_NUM_DIGITS,
			PH_NUM_STOP: begin
				if (num_slot())
					add_res(K_NUMBER, 4'(pp_pos + 5'd2), 0, 0, num_value());
				else
					add_res(K_END, 4'(pp_pos + 5'd2), 0, 0, 0);
				start_line();
			end
			default: ;
		endcase
	endtask

	// predict all results of one accepted request byte into step_res
	task automatic predict_results(input logic [7:0] b, input logic eob);
		step_res.delete();
		if (pp_cr) begin
			pp_cr = 1'b0;
			if (b == CH_LF) begin
				parse_line_end();
			end else begin
				parse_data(CH_CR);
				if (b == CH_CR)
					pp_cr = 1'b1;
				else
					parse_data(b);
			end
		end else if (b == CH_CR) begin
			pp_cr = 1'b1;
		end else begin
			parse_data(b);
		end
		if (eob) begin
			if (pp_cr) begin
				pp_cr = 1'b0;
				parse_data(CH_CR);
			end
			if (pp_phase != PH_DONE && pp_phase != PH_DEAD)
				add_res(K_BAD, 0, 0, 0, 0);
			parser_reset();
		end
		if (step_res.size() > 0)
			step_res[step_res.size() - 1].last_of_step = 1'b1;
	endtask

	task automatic push_text(input string s, input bit eob_at_end);
		for (int i = 0; i < s.len(); i++) begin
			req_bytes.push_back(s[i]);
			req_eob.push_back(eob_at_end && i == s.len() - 1);
		end
	endtask

	function automatic string rand_token(input int n);
		string s;
		byte c;
		s = "";
		for (int i = 0; i < n; i++) begin
			c = $urandom_range(33, 126);
			s = {s, string'(c)};
		end
		return s;
	endfunction

	function automatic string mix_case(input string s);
		for (int i = 0; i < s.len(); i++)
			if ($urandom_range(0, 1) && s[i] >= "A" && s[i] <= "Z")
				s[i] = s[i] + 8'd32;
		return s;
	endfunction

	// build one random request, mostly well formed
	task automatic push_random_request();
		string s;
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			// raw noise
			for (int i = $urandom_range(1, 8); i > 0; i--) begin
				req_bytes.push_back($urandom_range(0, 255));
				req_eob.push_back(1'b0);
			end
			req_bytes.push_back($urandom_range(0, 255));
			req_eob.push_back(1'b1);
			return;
		end
		s = {mix_case(meth_text($urandom_range(0, 2))), " "};
		if ($urandom_range(0, 3) == 0)
			s = {s, "\t"};
		case ($urandom_range(0, 4))
			0: s = {s, "/", rand_token($urandom_range(0, 5))};
			1: s = {s, "/a?", rand_token($urandom_range(0, 4))};
			2: s = {s, "?", rand_token($urandom_range(0, 3))};
			default: s = {s, "/", rand_token($urandom_range(1, 3)), "?x=1"};
		endcase
		s = {s, " HTTP/1.1\r\n"};
		for (int h = $urandom_range(0, 3); h > 0; h--) begin
			int slot;
			slot = $urandom_range(0, 11);
			if (slot == 11) begin
				s = {s, "X-", rand_token($urandom_range(1, 3)), ": v\r\n"};
			end else begin
				s = {s, mix_case(hdr_text(slot))};
				if (slot >= SLOT_KA) begin
					if ($urandom_range(0, 2) == 0) begin
						if ($urandom_range(0, 1))
							s = {s, "-"};
						else
							s = {s, "+"};
					end
					if ($urandom_range(0, 3) == 0)
						s = {s, "99999999999"};
					else
						s = {s, $sformatf("%0d", $urandom_range(0, 9999))};
					if ($urandom_range(0, 3) == 0)
						s = {s, "x\r"};
				end else begin
					s = {s, rand_token($urandom_range(0, 3))};
				end
				s = {s, "\r\n"};
			end
		end
		if ($urandom_range(0, 5) != 0)
			s = {s, "\r\n"};
		if ($urandom_range(0, 3) == 0)
			s = {s, rand_token($urandom_range(1, 3))};
		if ($urandom_range(0, 5) == 0)
			s = {s, "\r"};
		push_text(s, 1'b1);
	endtask

	function automatic result_t mk(input logic [2:0] k, input logic [1:0] m);
		result_t r;
		r = '0;
		r.out_kind = k;
		r.method_code = m;
		r.last_of_step = 1'b1;
		return r;
	endfunction

	task automatic add_row(input logic [7:0] b, input logic eob, input bit typed,
			input result_t want);
		dir_row_t d;
		d.b = b;
		d.eob = eob;
		d.typed = typed;
		d.want = want;
		dir_rows.push_back(d);
	endtask

	// stimulus driver: drive at the falling edge, request accepted at rising edge
	task automatic send_byte(input logic [7:0] b, input logic eob);
		req_in.valid <= 1'b1;
		req_in.data_byte <= b;
		req_in.end_of_buffer <= eob;
		do
			@(posedge clk);
		while (!req_in.ready);
		predict_results(b, eob);
		foreach (step_res[i])
			expected_res.push_back(step_res[i]);
		@(negedge clk);
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 2) == 0)
			n = 0;
		if (n > 0) begin
			req_in.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	initial begin
		int n;
		clk = 1'b0;
		arst_n = 1'b0;
		req_in.valid = 1'b0;
		req_in.data_byte = '0;
		req_in.end_of_buffer = 1'b0;
		res_out.ready = 1'b0;
		mismatches = 0;
		timed_out = 0;
		stim_done = 0;
		hold_results = 0;
		parser_reset();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table: unknown method, extremes, end-of-buffer cases
		add_row(8'h00, 1'b0, 1, mk(K_BAD, 0));
		add_row(8'hFF, 1'b1, 0, '0);
		add_row("G", 1'b0, 0, '0);
		add_row("e", 1'b0, 0, '0);
		add_row("t", 1'b0, 1, mk(K_METHOD, 2'd1));
		add_row(" ", 1'b1, 1, mk(K_BAD, 0));
		add_row("h", 1'b0, 0, '0);
		add_row("E", 1'b0, 0, '0);
		add_row("A", 1'b0, 0, '0);
		add_row("d", 1'b0, 1, mk(K_METHOD, 2'd3));
		add_row(" ", 1'b0, 0, '0);
		add_row(8'hFF, 1'b0, 0, '0);
		add_row(CH_CR, 1'b0, 0, '0);
		add_row(CH_CR, 1'b1, 0, '0);
		add_row("P", 1'b0, 0, '0);
		add_row(CH_CR, 1'b0, 0, '0);
		add_row(CH_LF, 1'b0, 1, mk(K_BAD, 0));
		add_row("x", 1'b1, 0, '0);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].typed) begin
				predict_results(dir_rows[i].b, dir_rows[i].eob);
				if (step_res.size() != 1 || step_res[0] != dir_rows[i].want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("table row %0d: exp k=%0d m=%0d / got %0d results",
							i, dir_rows[i].want.out_kind, dir_rows[i].want.method_code,
							step_res.size());
				end
				parser_reset();
				for (int j = 0; j < i; j++)
					predict_results(dir_rows[j].b, dir_rows[j].eob);
			end
			send_byte(dir_rows[i].b, dir_rows[i].eob);
		end

		// directed request: saturated numbers, repeated header, blank-line end
		push_text("POST /p?q HTTP/1.1\r\n", 0);
		push_text("Content-Length: 99999999999\r\nKeep-Alive: -99999999999\r\n", 0);
		push_text("Host: a\r\nHost: dup\r\n\r\nbody", 1);
		push_text("GET ?\r\nKeep-Alive: \r\n\r\n", 1);
		while (req_bytes.size() > 0) begin
			send_byte(req_bytes.pop_front(), req_eob.pop_front());
			idle_gap();
		end

		// pause until every expected result has come
		req_in.valid <= 1'b0;
		while (expected_res.size() > 0)
			@(negedge clk);

		// random requests; one long receiver hold-off partway through
		n = 0;
		while (n < 150) begin
			if (req_bytes.size() == 0)
				push_random_request();
			if (n == 60)
				hold_results = 1;
			send_byte(req_bytes.pop_front(), req_eob.pop_front());
			n++;
			idle_gap();
		end
		while (req_bytes.size() > 0) begin
			send_byte(req_bytes.pop_front(), req_eob.pop_front());
			idle_gap();
		end
		req_in.valid <= 1'b0;
		stim_done = 1;
	end

	// receiver: random back-pressure plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			res_out.ready <= 1'b0;
		end else if (hold_results) begin
			res_out.ready <= 1'b0;
			stall_cycles = stall_cycles + 1;
			if (stall_cycles >= 200)
				hold_results = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			res_out.ready <= 1'b0;
		end else begin
			res_out.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	initial stall_cycles = 0;

	// check every accepted result against the oldest expectation
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && res_out.valid && res_out.ready) begin
			got.out_kind = res_out.out_kind;
			got.field_id = res_out.field_id;
			got.value_byte = res_out.value_byte;
			got.method_code = res_out.method_code;
			got.number_value = res_out.number_value;
			got.last_of_step = res_out.last_of_step;
			if (expected_res.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result kind=%0d field=%0d", got.out_kind,
						got.field_id);
			end else begin
				want = expected_res.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp k=%0d f=%0d v=%h m=%0d n=%0d l=%0d / got k=%0d f=%0d v=%h m=%0d n=%0d l=%0d",
							want.out_kind, want.field_id, want.value_byte,
							want.method_code, want.number_value, want.last_of_step,
							got.out_kind, got.field_id, got.value_byte,
							got.method_code, got.number_value, got.last_of_step);
				end
			end
		end
	end

	// end of run: drain, settle, then report
	initial begin
		wait (stim_done);
		while (expected_res.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_res.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2ms;
		$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/hre_pkg.sv
src/hre_in_if.sv
src/hre_out_if.sv
src/hre_front.sv
src/hre_queue.sv
src/hre_back.sv
src/http_request_header_extractor.sv
verif/http_request_header_extractor_tb.sv
